[hdl/pu_pkg.sv]
// ----------------------------------------------------------------------------
// pu_pkg: shared types and tables for the permutation unrank core
// Factorial table, field widths and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package pu_pkg;

  localparam int RankW     = 63;
  localparam int LenW      = 7;
  localparam int TailMax   = 21;
  localparam int TailW     = 5;
  localparam int FactW     = 62;
  localparam int MaxNDflt  = 64;

  typedef logic [RankW-1:0] rank_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [TailW-1:0] tail_t;
  typedef logic [FactW-1:0] fact_t;

  typedef struct packed {
    logic load;
    logic fail_ld;
    logic search;
    logic pre;
    logic cnt_inc;
    logic div;
    logic scan;
    logic tail_next;
  } pu_cmd_t;

  typedef struct packed {
    logic bad_req;
    logic search_over;
    logic search_hit;
    logic pre_more;
    logic div_ge;
    logic scan_pick;
    logic pos_zero;
  } pu_stat_t;

  function automatic fact_t fact_f(input tail_t idx);
    fact_t f;
    case (idx)
      5'd0:    f = 62'd1;
      5'd1:    f = 62'd1;
      5'd2:    f = 62'd2;
      5'd3:    f = 62'd6;
      5'd4:    f = 62'd24;
      5'd5:    f = 62'd120;
      5'd6:    f = 62'd720;
      5'd7:    f = 62'd5040;
      5'd8:    f = 62'd40320;
      5'd9:    f = 62'd362880;
      5'd10:   f = 62'd3628800;
      5'd11:   f = 62'd39916800;
      5'd12:   f = 62'd479001600;
      5'd13:   f = 62'd6227020800;
      5'd14:   f = 62'd87178291200;
      5'd15:   f = 62'd1307674368000;
      5'd16:   f = 62'd20922789888000;
      5'd17:   f = 62'd355687428096000;
      5'd18:   f = 62'd6402373705728000;
      5'd19:   f = 62'd121645100408832000;
      5'd20:   f = 62'd2432902008176640000;
      default: f = 62'd0;
    endcase
    return f;
  endfunction

endpackage

[hdl/pu_if.sv]
// ----------------------------------------------------------------------------
// pu_req_if / pu_res_if: valid/ready channels of the permutation unrank core
// Request carries rank and length; result carries one permutation element.
// ----------------------------------------------------------------------------
interface pu_req_if import pu_pkg::*; ();
  logic  valid;
  logic  ready;
  rank_t rank;
  len_t  perm_length;
  modport source (output valid, output rank, output perm_length, input ready);
  modport sink   (input valid, input rank, input perm_length, output ready);
endinterface

interface pu_res_if import pu_pkg::*; ();
  logic valid;
  logic ready;
  len_t element_value;
  logic last;
  logic failed;
  modport source (output valid, output element_value, output last, output failed,
                  input ready);
  modport sink   (input valid, input element_value, input last, input failed,
                  output ready);
endinterface

[hdl/pu_ctrl.sv]
// ----------------------------------------------------------------------------
// pu_ctrl: sequencer of the permutation unrank core
// Walks check, tail search, prefix output, digit division and value scan.
// ----------------------------------------------------------------------------
module pu_ctrl import pu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     res_valid,
  input  logic     res_ready,
  input  pu_stat_t stat,
  output pu_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SEARCH   = 4'd2;
  localparam logic [3:0] S_PREFIX   = 4'd3;
  localparam logic [3:0] S_OUT_PRE  = 4'd4;
  localparam logic [3:0] S_DIV      = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_OUT_TAIL = 4'd7;
  localparam logic [3:0] S_OUT_FAIL = 4'd8;

  logic [3:0] state, state_next;

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT_PRE) || (state == S_OUT_TAIL) ||
                     (state == S_OUT_FAIL);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad_req) begin
          cmd.fail_ld = 1'b1;
          state_next = S_OUT_FAIL;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_over) begin
          cmd.fail_ld = 1'b1;
          state_next = S_OUT_FAIL;
        end else begin
          cmd.search = 1'b1;
          if (stat.search_hit) state_next = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cmd.pre = 1'b1;
        state_next = stat.pre_more ? S_OUT_PRE : S_DIV;
      end
      S_OUT_PRE: begin
        if (res_ready) begin
          cmd.cnt_inc = 1'b1;
          state_next = S_PREFIX;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (!stat.div_ge) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_pick) state_next = S_OUT_TAIL;
      end
      S_OUT_TAIL: begin
        if (res_ready) begin
          if (stat.pos_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.tail_next = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_OUT_FAIL: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[hdl/pu_dp.sv]
// ----------------------------------------------------------------------------
// pu_dp: datapath of the permutation unrank core
// Holds rank, remainder, digit, used flags and the result word registers.
// ----------------------------------------------------------------------------
module pu_dp import pu_pkg::*; #(
  parameter int MAX_N = MaxNDflt
) (
  input  logic     clk,
  input  rank_t    req_rank,
  input  len_t     req_len,
  input  pu_cmd_t  cmd,
  output pu_stat_t stat,
  output len_t     element_value,
  output logic     last,
  output logic     failed
);

  localparam len_t MaxNL = LenW'(MAX_N);

  rank_t            rank;
  rank_t            rem;
  len_t             n;
  len_t             cnt;
  len_t             base;
  tail_t            i;
  tail_t            m;
  tail_t            pos;
  tail_t            k;
  tail_t            s;
  logic [TailMax-1:0] used;

  rank_t fact_pos;
  rank_t fact_i;

  assign fact_pos = {1'b0, fact_f(pos)};
  assign fact_i   = {1'b0, fact_f(i)};

  assign stat.bad_req     = (rank == '0) || (n == '0) || (n > MaxNL);
  assign stat.search_over = ({2'b00, i} > n);
  assign stat.search_hit  = (i >= TailW'(TailMax)) || (fact_i >= rank);
  assign stat.pre_more    = (cnt < base);
  assign stat.div_ge      = (rem >= fact_pos);
  assign stat.scan_pick   = !used[s] && (k == '0);
  assign stat.pos_zero    = (pos == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rank <= req_rank;
      n    <= req_len;
      i    <= TailW'(1);
    end
    if (cmd.fail_ld) begin
      element_value <= '0;
      last          <= 1'b1;
      failed        <= 1'b1;
    end
    if (cmd.search) begin
      if (stat.search_hit) begin
        m    <= i;
        base <= n - {2'b00, i};
        cnt  <= '0;
      end else begin
        i <= i + TailW'(1);
      end
    end
    if (cmd.pre) begin
      if (stat.pre_more) begin
        element_value <= cnt + LenW'(1);
        last          <= (cnt + LenW'(1) == n);
        failed        <= 1'b0;
      end else begin
        rem  <= rank - RankW'(1);
        pos  <= m - TailW'(1);
        used <= '0;
        k    <= '0;
      end
    end
    if (cmd.cnt_inc) cnt <= cnt + LenW'(1);
    // one subtraction of pos factorial per cycle
    if (cmd.div) begin
      if (stat.div_ge) begin
        rem <= rem - fact_pos;
        k   <= k + TailW'(1);
      end else begin
        s <= '0;
      end
    end
    // step to the k-th free value
    if (cmd.scan) begin
      if (!used[s]) begin
        if (k == '0) begin
          used[s]       <= 1'b1;
          element_value <= base + {2'b00, s} + LenW'(1);
          last          <= (cnt + LenW'(1) == n);
          failed        <= 1'b0;
        end else begin
          k <= k - TailW'(1);
        end
      end
      s <= s + TailW'(1);
    end
    if (cmd.tail_next) begin
      cnt <= cnt + LenW'(1);
      pos <= pos - TailW'(1);
      k   <= '0;
    end
  end

endmodule

[hdl/permutation_unrank_core.sv]
// ----------------------------------------------------------------------------
// permutation_unrank_core: lexicographic permutation unranking
// Emits the rank-th permutation of 1..n one word at a time, or one failed word.
// ----------------------------------------------------------------------------
//  channel | dir | words per request   | payload
//  req     | in  | 1                   | rank[62:0], perm_length[6:0]
//  res     | out | n, or 1 when failed | element_value[6:0], last, failed
//
//  One request at a time; req.ready is high only while no request is in work.
//  A request passes the check, the tail search and one output step per prefix
//  word, then per tail digit the subtraction loop, the free-value scan and
//  one output word.
//  The digit loop subtracts one factorial at a time; the scan steps one pointer.
//  Reset is synchronous and returns the sequencer to idle; res.ready low holds
//  the current word.
module permutation_unrank_core import pu_pkg::*; #(
  parameter int MAX_N = MaxNDflt
) (
  input logic clk,
  input logic rst,
  pu_req_if.sink   req,
  pu_res_if.source res
);

  pu_cmd_t  cmd;
  pu_stat_t stat;

  pu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pu_dp #(.MAX_N(MAX_N)) u_dp (
    .clk           (clk),
    .req_rank      (req.rank),
    .req_len       (req.perm_length),
    .cmd           (cmd),
    .stat          (stat),
    .element_value (res.element_value),
    .last          (res.last),
    .failed        (res.failed)
  );

endmodule

[hdl/pu_checker.sv]
// ----------------------------------------------------------------------------
// pu_checker: port-level assertions for the permutation unrank core
// Checks result word hold, failed word form and one-request-at-a-time order.
// ----------------------------------------------------------------------------
module pu_checker import pu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input len_t element_value,
  input logic last,
  input logic failed
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(element_value) &&
    $stable(last) && $stable(failed))
    else $error("result word changed while stalled");

  a_fail_form: assert property (@(posedge clk) disable iff (rst)
    res_valid && failed |-> last && (element_value == '0))
    else $error("failed word not marked last or nonzero");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !req_ready)
    else $error("request taken while result pending");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !res_valid && !req_ready)
    else $error("result or ready right after request accept");

endmodule

bind permutation_unrank_core pu_checker u_pu_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .element_value (res.element_value),
  .last          (res.last),
  .failed        (res.failed)
);

[test/pu_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_tb_if: testbench channel helpers
// Holds no logic; the block's own interfaces in hdl/pu_if.sv carry the words.
// ----------------------------------------------------------------------------
package pu_tb_pkg;
  import pu_pkg::*;

  typedef struct packed {
    len_t element_value;
    logic last;
    logic failed;
  } perm_word_t;
endpackage

[test/permutation_unrank_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank_core_tb: self-checking bench for the unrank core
// Drives rank/length requests with random gaps, predicts every permutation
// word and compares the result stream in order, field by field.
// ----------------------------------------------------------------------------
module permutation_unrank_core_tb;
  import pu_pkg::*;
  import pu_tb_pkg::*;

  localparam int WatchLimit = 20000;

  class perm_scoreboard;
    perm_word_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // expand one request into the words of its permutation
    function void note_request(rank_t rank, len_t n);
      logic [63:0] fact[0:20];
      logic [63:0] rem, k, r;
      bit used[0:20];
      int m, base, cnt, pick;
      perm_word_t w;
      fact[0] = 1;
      for (int i = 1; i <= 20; i++) fact[i] = fact[i-1] * i;
      r = {1'b0, rank};
      m = 0;
      if (r == 0 || n == 0 || n > 64) begin
        w = '{element_value: '0, last: 1'b1, failed: 1'b1};
        pending.push_back(w);
        return;
      end
      for (int i = 1; i <= n; i++) begin
        if (i >= 21 || fact[i] >= r) begin
          m = i;
          break;
        end
      end
      // rank above n factorial
      if (m == 0) begin
        w = '{element_value: '0, last: 1'b1, failed: 1'b1};
        pending.push_back(w);
        return;
      end
      base = n - m;
      cnt = 0;
      for (int i = 1; i <= base; i++) begin
        w = '{element_value: len_t'(i), last: (cnt + 1 == n), failed: 1'b0};
        pending.push_back(w);
        cnt++;
      end
      for (int s = 0; s < 21; s++) used[s] = 0;
      rem = r - 1;
      for (int pos = m - 1; pos >= 0; pos--) begin
        k = rem / fact[pos];
        rem = rem % fact[pos];
        pick = -1;
        for (int s = 0; s < m && s < 21; s++) begin
          if (!used[s]) begin
            if (k == 0) begin
              pick = s;
              break;
            end
            k--;
          end
        end
        if (pick < 0) begin
          for (int s = m - 1; s >= 0; s--) begin
            if (!used[s]) begin
              pick = s;
              break;
            end
          end
        end
        if (pick < 0) pick = 0;
        used[pick] = 1;
        w = '{element_value: len_t'(base + pick + 1), last: (cnt + 1 == n), failed: 1'b0};
        pending.push_back(w);
        cnt++;
      end
    endfunction

    function void check_word(perm_word_t got);
      perm_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word value=%0d last=%0b failed=%0b",
                 $time, got.element_value, got.last, got.failed);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.element_value !== want.element_value) begin
        $display("%0t: element_value expected %0d actual %0d",
                 $time, want.element_value, got.element_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
      if (got.failed !== want.failed) begin
        $display("%0t: failed expected %0b actual %0b", $time, want.failed, got.failed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int idle_cycles = 0;
  bit stim_done = 0;
  perm_scoreboard sb = new();

  pu_req_if req();
  pu_res_if res();

  permutation_unrank_core uut (.clk(clk), .rst(rst), .req(req), .res(res));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.rank = '0;
    req.perm_length = '0;
    res.ready = 1'b0;
  end

  // sample at the rising edge; score results and count quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready)
        sb.check_word('{element_value: res.element_value, last: res.last,
                        failed: res.failed});
      if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stall per word, with stall-free stretches
  initial begin
    int wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_n > 0) begin
        res.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_request(rank_t rank, len_t n, bit no_gap = 0);
    int wait_n;
    wait_n = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    repeat (wait_n) @(negedge clk);
    req.rank <= rank;
    req.perm_length <= n;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(rank, n);
    @(negedge clk);
    req.valid <= 1'b0;
    // let the drop of valid settle before the next word is driven
    @(negedge clk);
  endtask

  function automatic rank_t rand_rank(int bits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (bits < 63) v = v & ((64'd1 << bits) - 1);
    return rank_t'(v);
  endfunction

  function automatic logic [63:0] factorial(int n);
    logic [63:0] f;
    f = 1;
    for (int i = 2; i <= n && i <= 20; i++) f = f * i;
    return f;
  endfunction

  initial begin
    int n, sel;
    logic [63:0] lim;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: invalid ranks, extremes of both fields, boundary ranks
    send_request('0, 7'd5);
    send_request('0, 7'd64);
    send_request(rank_t'(1), 7'd1);
    send_request(rank_t'(2), 7'd1);
    send_request(rank_t'(1), 7'd64);
    send_request(rank_t'(2), 7'd2);
    send_request(rank_t'(3), 7'd2);
    send_request(rank_t'(6), 7'd3);
    send_request(rank_t'(7), 7'd3);
    send_request(rank_t'(120), 7'd5);
    send_request(rank_t'(121), 7'd5);
    send_request(rank_t'(factorial(20)), 7'd20);
    send_request(rank_t'(factorial(20) + 1), 7'd20);
    send_request(rank_t'(factorial(20) + 1), 7'd21);
    send_request({63{1'b1}}, 7'd64);
    send_request({63{1'b1}}, 7'd21);
    send_request({63{1'b1}}, 7'd20);
    send_request(rank_t'(63'h2AAA_AAAA_AAAA_AAAA), 7'd30);
    send_request(rank_t'(63'h5555_5555_5555_5555), 7'd64);
    send_request(rank_t'(factorial(12)), 7'd12);
    send_request('0, 7'd0);
    send_request(rank_t'(5), 7'd0);
    send_request(rank_t'(1), 7'd65);
    send_request(rank_t'(9), 7'd127);

    // hold until every expected word has drained
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);

    for (int it = 0; it < 400; it++) begin
      sel = $urandom_range(0, 19);
      n = (sel < 14) ? $urandom_range(1, 12) : $urandom_range(1, 64);
      lim = factorial(n);
      if (sel == 0) send_request('0, len_t'(n));
      else if (sel == 1) send_request(rand_rank(63), len_t'($urandom_range(0, 127)),
                                      $urandom_range(0, 1));
      else if (sel == 2 && n <= 20) send_request(rank_t'(lim + $urandom_range(1, 50)),
                                                 len_t'(n));
      else if (n >= 21) send_request(rand_rank($urandom_range(1, 63)) | rank_t'(1),
                                     len_t'(n));
      else send_request(rank_t'(({$urandom, $urandom} % lim) + 1), len_t'(n),
                        $urandom_range(0, 1));
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
